// ===== sv/rbis_pkg.sv =====
// ---------------------------------------------------------------------------
// rbis_pkg
// Shared constants and the state type for the run boundary index set.
// ---------------------------------------------------------------------------
package rbis_pkg;

	localparam int MAX_BOUNDS_DEF = 64;
	localparam int POS_BITS_DEF   = 16;
	localparam int ORD_W          = 16;
	localparam int FUNC_W         = 3;

	localparam logic [FUNC_W-1:0] FN_SET_RANGE = 3'd0;
	localparam logic [FUNC_W-1:0] FN_CLR_RANGE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_CLR_ALL   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_CONTAINS  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_RANK      = 3'd4;
	localparam logic [FUNC_W-1:0] FN_SELECT    = 3'd5;
	localparam logic [FUNC_W-1:0] FN_COUNT     = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_INS  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

endpackage

// ===== sv/rbis_bank_mem.sv =====
// ---------------------------------------------------------------------------
// rbis_bank_mem
// Two-bank boundary store, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module rbis_bank_mem #(
	parameter int AW = 6,
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW:0]   waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW:0]   raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [2**(AW+1)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/run_boundary_index_set_core.sv =====
// ---------------------------------------------------------------------------
// run_boundary_index_set_core
// Position set held as sorted run boundaries in a ping-pong memory.
//
// Usage: drive func and its operands with start high while busy is low; the
// word is taken at that edge. One result word follows, shown for exactly one
// cycle with done high; the receiver cannot stall it.
// Every scanning operation (range set/clear, contains, rank, select, count)
// walks the active bank one boundary per cycle, reading one entry a cycle.
// A range update copies surviving boundaries into the other bank and flips
// banks on success; the bank is left alone on overflow.
// Queries pass through SCAN and FIN, range updates through SCAN, INS and FIN;
// clear all, unused codes and reversed ranges go straight to FIN. The next
// word is taken in the cycle done is shown.
// Reset: empty set (one boundary), busy low. No memory clearing pass.
// ---------------------------------------------------------------------------
module run_boundary_index_set_core #(
	parameter int MAX_BOUNDS = rbis_pkg::MAX_BOUNDS_DEF,
	parameter int POS_BITS   = rbis_pkg::POS_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [rbis_pkg::FUNC_W-1:0] func,
	input  logic [POS_BITS-1:0]         range_first,
	input  logic [POS_BITS-1:0]         range_last,
	input  logic [POS_BITS-1:0]         position,
	input  logic [rbis_pkg::ORD_W-1:0]  ordinal,
	output logic                        done,
	output logic [POS_BITS:0]           answer,
	output logic                        hit,
	output logic                        overflow,
	output logic                        set_empty
);

	import rbis_pkg::*;

	localparam int AW  = $clog2(MAX_BOUNDS);
	localparam int CW  = $clog2(MAX_BOUNDS + 1);
	localparam int WPW = $clog2(MAX_BOUNDS + 4);
	localparam int W   = POS_BITS + 1;
	localparam int RW  = (W > ORD_W) ? W : ORD_W + 1;
	localparam logic [W-1:0]   LIMIT = {1'b1, {POS_BITS{1'b0}}};
	localparam logic [WPW-1:0] WP_MAX = WPW'(MAX_BOUNDS);

	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic frm_q, bank_q;
	logic [FUNC_W-1:0] func_q;
	logic mark_q, v_q;
	logic [W-1:0] f_q, fm1_q, l1_q, pos_q;
	logic [CW-1:0] k_q;
	logic [W-1:0] s_q, ans_q, lastb_q;
	logic par_q, found_q, memhit_q, over_q, fins_q, lins_q;
	logic [RW-1:0] acc_q, rem_q;
	logic [WPW-1:0] wp_q;
	logic [AW-1:0] fslot_q, lslot_q;
	logic done_q, hit_q, ovf_q, empty_q;
	logic [W-1:0] answer_q;

	logic [W-1:0] rdata, e_w, len, wdata;
	logic [AW:0] raddr, waddr;
	logic we;
	logic last, m, in_pos, f_in, l_in, f_need, l_need, copy, add_en;
	logic [W-1:0] add_val;
	logic [WPW-1:0] wp_a, wp_b, wp_c;
	logic [RW-1:0] len_r;
	logic [CW-1:0] cnt_n;
	logic [W-1:0] ans_n;
	logic accept, is_mark, is_query;

	rbis_bank_mem #(.AW(AW), .DW(W)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign is_mark = (func inside {FN_SET_RANGE, FN_CLR_RANGE}) && (range_first <= range_last);
	assign is_query = func inside {FN_CONTAINS, FN_RANK, FN_SELECT, FN_COUNT};

	assign raddr = {bank_q, (state_q == ST_SCAN) ? AW'(k_q + 1'b1) : AW'(1)};

	always_comb begin
		last    = (k_q == cnt_q);
		e_w     = last ? LIMIT : rdata;
		m       = frm_q ^ par_q;
		len     = e_w - s_q;
		len_r   = RW'(len);
		in_pos  = (pos_q >= s_q) && (pos_q < e_w);
		f_in    = (f_q != '0) && (fm1_q >= s_q) && (fm1_q < e_w);
		l_in    = (l1_q >= s_q) && (l1_q < e_w);
		f_need  = mark_q && f_in && (m != v_q);
		l_need  = mark_q && ((l_in && (m != v_q)) || (last && (l1_q == LIMIT) && v_q));
		copy    = mark_q && !last && ((rdata < f_q) || (rdata > l1_q));
		wp_a    = wp_q + WPW'(f_need);
		wp_b    = wp_a + WPW'(l_need);
		wp_c    = wp_b + WPW'(copy);
		add_en  = m && ((func_q == FN_COUNT) || ((func_q == FN_RANK) && (pos_q >= s_q)));
		add_val = ((func_q == FN_RANK) && (pos_q < e_w)) ? (pos_q - s_q) : len;
	end

	always_comb begin
		we    = 1'b0;
		waddr = {~bank_q, wp_b[AW-1:0]};
		wdata = rdata;
		case (state_q)
			ST_SCAN: begin
				we = copy && (wp_b < WP_MAX);
			end
			ST_INS: begin
				we    = fins_q && !over_q;
				waddr = {~bank_q, fslot_q};
				wdata = f_q;
			end
			ST_FIN: begin
				we    = mark_q && lins_q && !over_q;
				waddr = {~bank_q, lslot_q};
				wdata = l1_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_comb begin
		cnt_n = cnt_q;
		if (mark_q && !over_q) begin
			cnt_n = wp_q[CW-1:0];
		end else if (func_q == FN_CLR_ALL) begin
			cnt_n = CW'(1);
		end
		ans_n = '0;
		case (func_q)
			FN_RANK:   ans_n = memhit_q ? acc_q[W-1:0] : '0;
			FN_SELECT: ans_n = found_q ? ans_q : ((cnt_q > CW'(1)) ? lastb_q - 1'b1 : '0);
			FN_COUNT:  ans_n = acc_q[W-1:0];
			default:   ans_n = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= CW'(1);
			frm_q   <= 1'b0;
			bank_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (is_mark || is_query) ? ST_SCAN : ST_FIN;
					end
				end
				ST_SCAN: begin
					if (last) begin
						state_q <= mark_q ? ST_INS : ST_FIN;
					end
				end
				ST_INS: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					cnt_q   <= cnt_n;
					if (mark_q && !over_q) begin
						bank_q <= ~bank_q;
						if (f_q == '0) begin
							frm_q <= v_q;
						end
					end else if (func_q == FN_CLR_ALL) begin
						frm_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= func;
			mark_q   <= is_mark;
			v_q      <= (func == FN_SET_RANGE);
			f_q      <= W'(range_first);
			fm1_q    <= W'(range_first) - 1'b1;
			l1_q     <= W'(range_last) + 1'b1;
			pos_q    <= W'(position);
			k_q      <= CW'(1);
			s_q      <= '0;
			par_q    <= 1'b0;
			acc_q    <= '0;
			rem_q    <= RW'(ordinal);
			found_q  <= 1'b0;
			ans_q    <= '0;
			lastb_q  <= '0;
			memhit_q <= 1'b0;
			wp_q     <= WPW'(1);
			over_q   <= 1'b0;
			fins_q   <= 1'b0;
			lins_q   <= 1'b0;
			fslot_q  <= '0;
			lslot_q  <= '0;
		end else if (state_q == ST_SCAN) begin
			k_q   <= k_q + 1'b1;
			s_q   <= e_w;
			par_q <= ~par_q;
			if (!last) begin
				lastb_q <= rdata;
			end
			if (in_pos) begin
				memhit_q <= m;
			end
			if (add_en) begin
				acc_q <= acc_q + RW'(add_val);
			end
			if (m && !found_q) begin
				if (rem_q < len_r) begin
					found_q <= 1'b1;
					ans_q   <= s_q + rem_q[W-1:0];
				end else begin
					rem_q <= rem_q - len_r;
				end
			end
			if (f_need) begin
				fins_q  <= 1'b1;
				fslot_q <= wp_q[AW-1:0];
			end
			if (l_need) begin
				lins_q  <= 1'b1;
				lslot_q <= wp_a[AW-1:0];
			end
			wp_q <= wp_c;
			if (wp_c > WP_MAX) begin
				over_q <= 1'b1;
			end
		end
		if (state_q == ST_FIN) begin
			answer_q <= ans_n;
			hit_q    <= (func_q inside {FN_CONTAINS, FN_RANK}) ? memhit_q
				: ((func_q == FN_SELECT) && found_q);
			ovf_q    <= mark_q && over_q;
			empty_q  <= (cnt_n <= CW'(1));
		end
	end

	assign done      = done_q;
	assign answer    = answer_q;
	assign hit       = hit_q;
	assign overflow  = ovf_q;
	assign set_empty = empty_q;

endmodule
